// ----- hw/rtl/pbski_pkg.sv -----
// shared types and constants for the prefix bucketed sorted key index
// used by every module of the block but pbski_ram; no dependencies
package pbski_pkg;

    localparam int MAX_ENTRIES     = 4096;
    localparam int MAX_PREFIX_BITS = 12;
    localparam int BUCKET_SLOTS    = (1 << MAX_PREFIX_BITS) + 1;

    localparam int KEY_W      = 64;
    localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_AW     = $clog2(MAX_ENTRIES);
    localparam int BKT_AW     = $clog2(BUCKET_SLOTS);
    localparam int BKT_W      = MAX_PREFIX_BITS;
    localparam int POS_W      = 13;
    localparam int ST_W       = 2;
    localparam int OP_W       = 2;
    localparam int KB_W       = 7;
    localparam int PB_W       = 4;
    localparam int KB_MAX     = 64;
    localparam int KB_RESET   = 64;
    localparam int PB_RESET   = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_BITS = 2'd1;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_FINISH = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_REJECT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RES_OK,
        RES_ABSENT,
        RES_REJECT,
        RES_FOUND
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CLOSE,
        S_BKT_USE,
        S_SEARCH,
        S_FINAL,
        S_FINAL2,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic latch;
        logic clear;
        logic close_step;
        logic store_key;
        logic mark_ready;
        logic bkt_read;
        logic search_init;
        logic search_step;
        logic final_step;
        logic res_set;
        res_t res_code;
        logic emit;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic load_reject;
        logic finish_reject;
        logic lookup_reject;
        logic lookup_empty;
        logic close_more;
        logic widest_gt1;
        logic search_more;
        logic key_less;
        logic key_eq;
        logic next_in_table;
        logic out_free;
    } stat_t;

endpackage

// ----- hw/rtl/pbski_ram.sv -----
// generic single write port, single read port memory with registered read
// no dependencies
module pbski_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/pbski_dp.sv -----
// datapath: config registers, table bookkeeping, key and bucket memories,
// search registers and the output register; depends on pbski_pkg, pbski_ram
module pbski_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pbski_pkg::cmd_t                   cmd,
    output pbski_pkg::stat_t                  stat,
    input  logic                              cfg_wr,
    input  logic [pbski_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pbski_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [pbski_pkg::OP_W-1:0]        operation,
    input  logic [pbski_pkg::KEY_W-1:0]       key,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [pbski_pkg::POS_W-1:0] position,
    output logic [pbski_pkg::ST_W-1:0]        status
);
    import pbski_pkg::*;

    // control state
    logic [KB_W-1:0]   key_bits_reg, key_bits_next;
    logic [PB_W-1:0]   prefix_bits_reg, prefix_bits_next;
    logic [CNT_W-1:0]  entry_reg, entry_next;
    logic [BKT_AW-1:0] closed_reg, closed_next;
    logic [CNT_W-1:0]  run_reg, run_next;
    logic [CNT_W-1:0]  widest_reg, widest_next;
    logic [KEY_W-1:0]  prev_reg, prev_next;
    logic              ready_reg, ready_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    op_t                      op_reg;
    logic [KEY_W-1:0]         key_reg;
    logic [CNT_W-1:0]         base_reg;
    logic [CNT_W-1:0]         size_reg;
    logic signed [POS_W-1:0]  res_pos_reg;
    status_t                  res_st_reg;
    logic signed [POS_W-1:0]  position_reg;
    status_t                  status_reg;

    logic [KB_W-1:0]   eff_kb;
    logic [PB_W-1:0]   eff_p;
    logic [KB_W-1:0]   shift_amt;
    logic [KEY_W-1:0]  key_shifted;
    logic [BKT_W-1:0]  bucket_idx;
    logic [BKT_AW-1:0] close_target;
    logic              too_wide;
    logic              cfg_hit;
    logic              clear_all;

    logic [CNT_W-1:0]  limit;
    logic [CNT_W-1:0]  base0;
    logic [CNT_W-1:0]  half;
    logic [CNT_W-1:0]  size_new;
    logic [CNT_W-1:0]  base_new;
    logic [CNT_W-1:0]  base_inc;
    logic [CNT_W-1:0]  key_rd_addr;
    logic              key_rd_en;

    logic [KEY_W-1:0]  key_rd_data;
    logic [CNT_W-1:0]  bkt_rd_data;

    // effective widths
    always_comb
    begin
        if (key_bits_reg == '0)
        begin
            eff_kb = KB_W'(1);
        end
        else if (key_bits_reg > KB_W'(KB_MAX))
        begin
            eff_kb = KB_W'(KB_MAX);
        end
        else
        begin
            eff_kb = key_bits_reg;
        end
    end

    always_comb
    begin
        eff_p = prefix_bits_reg;
        if (KB_W'(eff_p) > eff_kb)
        begin
            eff_p = eff_kb[PB_W-1:0];
        end
        if (eff_p > PB_W'(MAX_PREFIX_BITS))
        begin
            eff_p = PB_W'(MAX_PREFIX_BITS);
        end
    end

    // a shift by the full 64 bits gives zero, so this covers key_bits of 64
    assign too_wide    = (key_reg >> eff_kb) != '0;
    assign shift_amt   = eff_kb - KB_W'(eff_p);
    assign key_shifted = key_reg >> shift_amt;
    assign bucket_idx  = (eff_p == '0) ? '0 : key_shifted[BKT_W-1:0];

    // load closes up to its own bucket, finish up to the slot past the last
    assign close_target = (op_reg == OP_LOAD) ? BKT_AW'(bucket_idx)
                                              : (BKT_AW'(1) << eff_p);

    assign cfg_hit   = cfg_wr && (cfg_index == CFG_KEY_BITS || cfg_index == CFG_PREFIX_BITS);
    assign clear_all = cmd.clear || cfg_hit;

    // search arithmetic
    assign limit    = entry_reg - widest_reg;
    assign base0    = (bkt_rd_data > limit) ? limit : bkt_rd_data;
    assign half     = size_reg >> 1;
    assign size_new = size_reg - half;
    assign base_new = stat.key_less ? (base_reg + half) : base_reg;
    assign base_inc = base_reg + CNT_W'(1);

    always_comb
    begin
        key_rd_addr = base_inc;
        if (cmd.search_init)
        begin
            key_rd_addr = stat.widest_gt1 ? (base0 + (widest_reg >> 1)) : base0;
        end
        else if (cmd.search_step)
        begin
            key_rd_addr = stat.search_more ? (base_new + (size_new >> 1)) : base_new;
        end
    end

    assign key_rd_en = cmd.search_init || cmd.search_step || cmd.final_step;

    // status to the controller
    always_comb
    begin
        stat.op            = op_reg;
        stat.load_reject   = ready_reg || (entry_reg >= CNT_W'(MAX_ENTRIES)) || too_wide
                             || ((entry_reg != '0) && (key_reg <= prev_reg));
        stat.finish_reject = ready_reg;
        stat.lookup_reject = !ready_reg;
        stat.lookup_empty  = too_wide || (entry_reg == '0) || (widest_reg == '0);
        stat.close_more    = (closed_reg <= close_target)
                             && (closed_reg < BKT_AW'(BUCKET_SLOTS));
        stat.widest_gt1    = widest_reg > CNT_W'(1);
        stat.search_more   = size_new > CNT_W'(1);
        stat.key_less      = key_rd_data < key_reg;
        stat.key_eq        = key_rd_data == key_reg;
        stat.next_in_table = base_inc < entry_reg;
        stat.out_free      = !out_valid_reg || !out_stall;
    end

    // memories
    pbski_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (cmd.store_key),
        .wr_addr (entry_reg[KEY_AW-1:0]),
        .wr_data (key_reg),
        .rd_en   (key_rd_en),
        .rd_addr (key_rd_addr[KEY_AW-1:0]),
        .rd_data (key_rd_data)
    );

    pbski_ram #(
        .WIDTH (CNT_W),
        .DEPTH (BUCKET_SLOTS)
    ) u_bkt_ram (
        .clk     (clk),
        .wr_en   (cmd.close_step),
        .wr_addr (closed_reg),
        .wr_data (entry_reg),
        .rd_en   (cmd.bkt_read),
        .rd_addr (BKT_AW'(bucket_idx)),
        .rd_data (bkt_rd_data)
    );

    // next values of control state
    always_comb
    begin
        key_bits_next    = key_bits_reg;
        prefix_bits_next = prefix_bits_reg;
        entry_next       = entry_reg;
        closed_next      = closed_reg;
        run_next         = run_reg;
        widest_next      = widest_reg;
        prev_next        = prev_reg;
        ready_next       = ready_reg;

        if (cfg_wr && cfg_index == CFG_KEY_BITS)
        begin
            key_bits_next = cfg_data[KB_W-1:0];
        end
        if (cfg_wr && cfg_index == CFG_PREFIX_BITS)
        begin
            prefix_bits_next = cfg_data[PB_W-1:0];
        end

        if (clear_all)
        begin
            entry_next  = '0;
            closed_next = '0;
            run_next    = '0;
            widest_next = '0;
            prev_next   = '0;
            ready_next  = 1'b0;
        end
        else
        begin
            if (cmd.close_step)
            begin
                widest_next = (run_reg > widest_reg) ? run_reg : widest_reg;
                run_next    = '0;
                closed_next = closed_reg + BKT_AW'(1);
            end
            if (cmd.store_key)
            begin
                entry_next = entry_reg + CNT_W'(1);
                run_next   = run_reg + CNT_W'(1);
                prev_next  = key_reg;
            end
            if (cmd.mark_ready)
            begin
                ready_next = 1'b1;
            end
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bits_reg    <= KB_W'(KB_RESET);
            prefix_bits_reg <= PB_W'(PB_RESET);
            entry_reg       <= '0;
            closed_reg      <= '0;
            run_reg         <= '0;
            widest_reg      <= '0;
            prev_reg        <= '0;
            ready_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            key_bits_reg    <= key_bits_next;
            prefix_bits_reg <= prefix_bits_next;
            entry_reg       <= entry_next;
            closed_reg      <= closed_next;
            run_reg         <= run_next;
            widest_reg      <= widest_next;
            prev_reg        <= prev_next;
            ready_reg       <= ready_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg  <= op_t'(operation);
            key_reg <= key;
        end
        if (cmd.search_init)
        begin
            base_reg <= base0;
            size_reg <= widest_reg;
        end
        else if (cmd.search_step)
        begin
            base_reg <= base_new;
            size_reg <= size_new;
        end
        else if (cmd.final_step)
        begin
            base_reg <= base_inc;
        end
        if (cmd.res_set)
        begin
            case (cmd.res_code)
                RES_OK:
                begin
                    res_pos_reg <= '1;
                    res_st_reg  <= ST_OK;
                end
                RES_ABSENT:
                begin
                    res_pos_reg <= '1;
                    res_st_reg  <= ST_ABSENT;
                end
                RES_REJECT:
                begin
                    res_pos_reg <= '1;
                    res_st_reg  <= ST_REJECT;
                end
                RES_FOUND:
                begin
                    res_pos_reg <= POS_W'(base_reg);
                    res_st_reg  <= ST_OK;
                end
                default:
                begin
                    res_pos_reg <= '1;
                    res_st_reg  <= ST_REJECT;
                end
            endcase
        end
        if (cmd.emit)
        begin
            position_reg <= res_pos_reg;
            status_reg   <= res_st_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign position  = position_reg;
    assign status    = status_reg;

endmodule

// ----- hw/rtl/pbski_ctrl.sv -----
// controller state machine: sequences decode, bucket closing, search and result
// depends on pbski_pkg
module pbski_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  pbski_pkg::stat_t stat,
    output pbski_pkg::cmd_t  cmd
);
    import pbski_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_CLEAR:  state_next = S_RESULT;
                    OP_LOAD:   state_next = stat.load_reject ? S_RESULT : S_CLOSE;
                    OP_FINISH: state_next = stat.finish_reject ? S_RESULT : S_CLOSE;
                    OP_LOOKUP:
                    begin
                        if (stat.lookup_reject || stat.lookup_empty)
                        begin
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_BKT_USE;
                        end
                    end
                    default:   state_next = S_RESULT;
                endcase
            end
            S_CLOSE:
            begin
                if (!stat.close_more)
                begin
                    state_next = S_RESULT;
                end
            end
            S_BKT_USE:
            begin
                state_next = stat.widest_gt1 ? S_SEARCH : S_FINAL;
            end
            S_SEARCH:
            begin
                if (!stat.search_more)
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                if (stat.key_less && stat.next_in_table)
                begin
                    state_next = S_FINAL2;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_FINAL2:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd          = '0;
        cmd.res_code = RES_OK;
        in_stall     = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.latch = in_valid;
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_CLEAR:
                    begin
                        cmd.clear   = 1'b1;
                        cmd.res_set = 1'b1;
                    end
                    OP_LOAD:
                    begin
                        if (stat.load_reject)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = RES_REJECT;
                        end
                    end
                    OP_FINISH:
                    begin
                        if (stat.finish_reject)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = RES_REJECT;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (stat.lookup_reject)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = RES_REJECT;
                        end
                        else if (stat.lookup_empty)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = RES_ABSENT;
                        end
                        else
                        begin
                            cmd.bkt_read = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = RES_REJECT;
                    end
                endcase
            end
            S_CLOSE:
            begin
                if (stat.close_more)
                begin
                    cmd.close_step = 1'b1;
                end
                else
                begin
                    cmd.res_set = 1'b1;
                    if (stat.op == OP_LOAD)
                    begin
                        cmd.store_key = 1'b1;
                    end
                    else
                    begin
                        cmd.mark_ready = 1'b1;
                    end
                end
            end
            S_BKT_USE:
            begin
                cmd.search_init = 1'b1;
            end
            S_SEARCH:
            begin
                cmd.search_step = 1'b1;
            end
            S_FINAL:
            begin
                if (stat.key_less)
                begin
                    if (stat.next_in_table)
                    begin
                        cmd.final_step = 1'b1;
                    end
                    else
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = RES_ABSENT;
                    end
                end
                else
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = stat.key_eq ? RES_FOUND : RES_ABSENT;
                end
            end
            S_FINAL2:
            begin
                cmd.res_set  = 1'b1;
                cmd.res_code = stat.key_eq ? RES_FOUND : RES_ABSENT;
            end
            S_RESULT:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                cmd.res_code = RES_OK;
            end
        endcase
    end

endmodule

// ----- hw/rtl/prefix_bucketed_sorted_key_index_core.sv -----
// one item in flight; the next enters in the cycle after the result register loads, even while that result waits
// clear and rejected items: decode goes straight on to the result state
// load and finish: buckets close one per step in the close state (finish may close up to 4097)
// lookup: bucket read, search steps over a widest-bucket window, one or two final compares; one key read per step
// reset clears the control state and sets key_bits to 64 and prefix bits to 12;
// memory contents stay undefined and need no clearing pass
module prefix_bucketed_sorted_key_index_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [pbski_pkg::OP_W-1:0]         operation,
    input  logic [pbski_pkg::KEY_W-1:0]        key,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [pbski_pkg::POS_W-1:0] position,
    output logic [pbski_pkg::ST_W-1:0]         status,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pbski_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pbski_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pbski_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    pbski_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    pbski_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .operation (operation),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .position  (position),
        .status    (status)
    );

endmodule

// ----- hw/rtl/pbski_checker.sv -----
// port level checks for the sorted key index, attached to the top level by bind
// depends on pbski_pkg and prefix_bucketed_sorted_key_index_core
module pbski_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [pbski_pkg::POS_W-1:0] position,
    input logic [pbski_pkg::ST_W-1:0]         status
);
    import pbski_pkg::*;

    // a found key is the only result with a real position
    a_pos_means_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && position != '1 |-> status == ST_OK)
        else $error("position given with a non-found status");

    a_reject_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_REJECT || status == ST_ABSENT) |-> position == '1)
        else $error("rejected or absent item carries a position");

    // an accepted item keeps the input blocked in the cycle after it is taken, before the next enters
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken on consecutive cycles");

    // a new result appears only as the block goes back to taking items
    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result appeared while input still blocked");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(position) && $stable(status))
        else $error("stalled result changed");

endmodule

bind prefix_bucketed_sorted_key_index_core pbski_checker u_pbski_checker (.*);

// ----- dv/pbski_index_checker.sv -----
`timescale 1ns / 100ps
// scoreboard for the prefix bucketed sorted key index: follows register writes, predicts
// one reply per accepted item and compares replies in order; depends on pbski_pkg
module pbski_index_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [pbski_pkg::OP_W-1:0]       operation,
    input  logic [pbski_pkg::KEY_W-1:0]      key,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [pbski_pkg::POS_W-1:0]      position,
    input  logic [pbski_pkg::ST_W-1:0]       status,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [pbski_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pbski_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                               fail_count,
    output int                               pending,
    output int                               checked
);
    import pbski_pkg::*;

    localparam logic [POS_W-1:0] NO_POS     = '1;
    localparam int               MAX_REPORT = 10;

    typedef struct {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
        status_t          st;
    } reply_t;

    logic [KEY_W-1:0] key_mem [MAX_ENTRIES];
    int unsigned      bkt_first [BUCKET_SLOTS];
    int unsigned      n_keys;
    int unsigned      n_closed;
    int unsigned      run_len;
    int unsigned      widest;
    logic [KEY_W-1:0] last_key;
    bit               sealed;
    logic [KB_W-1:0]  kb_reg;
    logic [PB_W-1:0]  pb_reg;
    reply_t           reply_q [$];
    int               n_fail;
    int               n_checked;

    function automatic int unsigned key_width();
        if (kb_reg == 0)
            return 1;
        if (kb_reg > KB_MAX)
            return KB_MAX;
        return kb_reg;
    endfunction

    function automatic int unsigned prefix_width();
        int unsigned p;
        p = pb_reg;
        if (p > key_width())
            p = key_width();
        if (p > MAX_PREFIX_BITS)
            p = MAX_PREFIX_BITS;
        return p;
    endfunction

    function automatic bit beyond_width(input logic [KEY_W-1:0] k);
        return key_width() < KEY_W && (k >> key_width()) != 0;
    endfunction

    function automatic int unsigned bucket_of(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] shifted;
        if (prefix_width() == 0)
            return 0;
        shifted = k >> (key_width() - prefix_width());
        return shifted[31:0];
    endfunction

    function automatic void empty_index();
        n_keys   = 0;
        n_closed = 0;
        run_len  = 0;
        widest   = 0;
        last_key = '0;
        sealed   = 1'b0;
    endfunction

    // every bucket up to and including last gets the current count as its start
    function automatic void close_buckets(input int unsigned last);
        while (n_closed <= last && n_closed < BUCKET_SLOTS)
        begin
            bkt_first[n_closed] = n_keys;
            if (run_len > widest)
                widest = run_len;
            run_len = 0;
            n_closed++;
        end
    endfunction

    function automatic reply_t predict_reply(input op_t op, input logic [KEY_W-1:0] k);
        reply_t      r;
        int unsigned b;
        int unsigned lim;
        int unsigned base;
        int unsigned span;
        int unsigned half;
        r.op  = op;
        r.key = k;
        r.pos = NO_POS;
        r.st  = ST_OK;
        case (op)
            OP_CLEAR:
                empty_index();
            OP_LOAD:
            begin
                if (sealed || n_keys >= MAX_ENTRIES || beyond_width(k) ||
                    (n_keys > 0 && k <= last_key))
                    r.st = ST_REJECT;
                else
                begin
                    close_buckets(bucket_of(k));
                    key_mem[n_keys] = k;
                    n_keys++;
                    run_len++;
                    last_key = k;
                end
            end
            OP_FINISH:
            begin
                if (sealed)
                    r.st = ST_REJECT;
                else
                begin
                    close_buckets(1 << prefix_width());
                    sealed = 1'b1;
                end
            end
            default:
            begin
                if (!sealed)
                    r.st = ST_REJECT;
                else if (beyond_width(k) || n_keys == 0 || widest == 0)
                    r.st = ST_ABSENT;
                else
                begin
                    // window of widest entries, pulled back so it ends inside the table
                    b    = bucket_of(k);
                    lim  = n_keys - widest;
                    base = (b < BUCKET_SLOTS) ? bkt_first[b] : lim;
                    span = widest;
                    if (base > lim)
                        base = lim;
                    while (span > 1)
                    begin
                        half = span / 2;
                        span -= half;
                        if (key_mem[base + half] < k)
                            base += half;
                    end
                    if (key_mem[base] < k)
                        base++;
                    if (base < n_keys && key_mem[base] == k)
                        r.pos = base[POS_W-1:0];
                    else
                        r.st = ST_ABSENT;
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_t head;
        if (!rst_n)
        begin
            kb_reg = KB_W'(KB_RESET);
            pb_reg = PB_W'(PB_RESET);
            empty_index();
            reply_q.delete();
            n_fail     = 0;
            n_checked  = 0;
            fail_count <= 0;
            pending    <= 0;
            checked    <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_checked++;
                if (reply_q.size() == 0)
                begin
                    if (n_fail < MAX_REPORT)
                        $display("%0t: reply with nothing outstanding: position %0d status %0d",
                                 $time, $signed(position), status);
                    n_fail++;
                end
                else
                begin
                    head = reply_q.pop_front();
                    if (position !== head.pos || status !== head.st)
                    begin
                        if (n_fail < MAX_REPORT)
                            $display({"%0t: %s key %h: expected position %0d status %s, ",
                                      "got position %0d status %0d"},
                                     $time, head.op.name(), head.key, $signed(head.pos),
                                     head.st.name(), $signed(position), status);
                        n_fail++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_KEY_BITS)
                begin
                    kb_reg = cfg_data[KB_W-1:0];
                    empty_index();
                end
                else if (cfg_index == CFG_PREFIX_BITS)
                begin
                    pb_reg = cfg_data[PB_W-1:0];
                    empty_index();
                end
            end
            if (in_valid && !in_stall)
                reply_q.push_back(predict_reply(op_t'(operation), key));
            fail_count <= n_fail;
            pending    <= reply_q.size();
            checked    <= n_checked;
        end
    end

endmodule

// ----- dv/tb_prefix_bucketed_sorted_key_index_core.sv -----
`timescale 1ns / 100ps
// testbench top for the prefix bucketed sorted key index: clock, reset, register writes,
// item stimulus and verdict; depends on pbski_pkg, the core and pbski_index_checker
module tb_prefix_bucketed_sorted_key_index_core;
    import pbski_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RANDOM_ITEMS = 1550;
    localparam int FILL_KEYS    = 256;
    // slowest run: every finish closing all buckets plus long gaps and stalls stays far below
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic [OP_W-1:0]         operation = OP_CLEAR;
    logic [KEY_W-1:0]        key       = '0;
    logic                    out_stall = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = CFG_KEY_BITS;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;
    logic                    in_stall;
    logic                    out_valid;
    logic signed [POS_W-1:0] position;
    logic [ST_W-1:0]         status;
    logic                    cfg_ready;

    int fail_count;
    int pending;
    int checked;
    int cycle_count = 0;
    int items_sent  = 0;
    int cfg_writes  = 0;
    int burst_left  = 0;
    int cur_kb      = KB_RESET;
    int mode_left   = 0;
    rx_mode_t rx_mode = RX_FREE;
    logic [KEY_W-1:0] table_keys [$];

    prefix_bucketed_sorted_key_index_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .position  (position),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pbski_index_checker index_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .key        (key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .position   (position),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver switches at random between stall patterns: none, light, heavy and periodic
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            rx_mode   <= rx_mode_t'($urandom_range(0, 3));
            mode_left <= $urandom_range(30, 300);
        end
        else
            mode_left <= mode_left - 1;
        case (rx_mode)
            RX_FREE:  out_stall <= 1'b0;
            RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:  out_stall <= (cycle_count % 7) < 3;
        endcase
    end

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [KEY_W-1:0] key_max();
        return (cur_kb >= KEY_W) ? '1 : ((64'd1 << cur_kb) - 64'd1);
    endfunction

    // uniform-ish in 1..span
    function automatic logic [KEY_W-1:0] rand_upto(input logic [KEY_W-1:0] span);
        if (span <= 1)
            return 64'd1;
        if (span[KEY_W-1:32] == 0)
            return {32'd0, $urandom_range(1, span[31:0])};
        return rand_key() % span + 64'd1;
    endfunction

    task automatic send_item(input op_t op, input logic [KEY_W-1:0] k);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        operation <= op;
        key       <= k;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic drain_replies();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        drain_replies();
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
        if (idx == CFG_KEY_BITS)
            cur_kb = (val == 0) ? 1 : (val > KB_MAX) ? KB_MAX : val;
        if (idx == CFG_KEY_BITS || idx == CFG_PREFIX_BITS)
            table_keys.delete();
    endtask

    task automatic load_next(input logic [KEY_W-1:0] span, output bit done);
        logic [KEY_W-1:0] room;
        logic [KEY_W-1:0] k;
        done = 1'b1;
        if (table_keys.size() == 0)
            k = ($urandom_range(0, 3) == 0) ? '0 : rand_key() & (key_max() >> $urandom_range(1, 4));
        else
        begin
            room = key_max() - table_keys[$];
            if (room == 0)
            begin
                done = 1'b0;
                return;
            end
            k = table_keys[$] + rand_upto((span < room) ? span : room);
        end
        send_item(OP_LOAD, k);
        table_keys.push_back(k);
    endtask

    // broken loads, early lookups and the odd clear in the middle of loading
    task automatic send_noise();
        int pick;
        pick = $urandom_range(0, 9);
        if (table_keys.size() > 0 && pick < 3)
            send_item(OP_LOAD, table_keys[$]);
        else if (table_keys.size() > 0 && table_keys[$] != 0 && pick < 5)
            send_item(OP_LOAD, table_keys[$] - rand_upto(table_keys[$]));
        else if (cur_kb < KEY_W && pick < 7)
            send_item(OP_LOAD, rand_key() | (64'd1 << cur_kb));
        else if (pick < 9)
            send_item(OP_LOOKUP, rand_key() & key_max());
        else
        begin
            send_item(OP_CLEAR, rand_key());
            table_keys.delete();
        end
    endtask

    task automatic lookup_some(input int n);
        int               pick;
        logic [KEY_W-1:0] k;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (table_keys.size() > 0 && pick < 55)
                k = table_keys[$urandom_range(0, table_keys.size() - 1)];
            else if (table_keys.size() > 0 && pick < 75)
                k = table_keys[$urandom_range(0, table_keys.size() - 1)] +
                    (($urandom_range(0, 1) == 0) ? 64'd1 : '1);
            else if (pick < 88)
                k = rand_key() & key_max();
            else if (pick < 94)
                k = (cur_kb < KEY_W) ? (rand_key() | (64'd1 << cur_kb)) : '1;
            else
                k = ($urandom_range(0, 1) == 0) ? '0 : key_max();
            if (pick == 96)
                send_item(OP_LOAD, k);
            else if (pick == 97)
                send_item(OP_FINISH, k);
            else
                send_item(OP_LOOKUP, k);
        end
    endtask

    task automatic run_table(input int n_load, input int n_look);
        logic [KEY_W-1:0] span;
        int               sb;
        bit               done;
        send_item(OP_CLEAR, rand_key());
        table_keys.delete();
        case ($urandom_range(0, 2))
            0: span = {32'd0, $urandom_range(1, 8)};
            1: span = key_max() / (n_load + 1) + 64'd1;
            default:
            begin
                sb   = $urandom_range(0, cur_kb);
                span = (sb >= KEY_W) ? '1 : (64'd1 << sb);
            end
        endcase
        for (int i = 0; i < n_load; i++)
        begin
            if ($urandom_range(0, 99) < 8)
                send_noise();
            else
            begin
                load_next(span, done);
                if (!done)
                    break;
            end
        end
        // now and then the finish is left out and the lookups bounce, save after a stray finish among them
        if ($urandom_range(0, 19) != 0)
            send_item(OP_FINISH, rand_key());
        lookup_some(n_look);
    endtask

    task automatic reconfigure();
        logic [CFG_DATA_W-1:0] kb_val;
        logic [CFG_DATA_W-1:0] pb_val;
        int                    pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            kb_val = CFG_DATA_W'($urandom_range(0, 127));
        else if (pick < 8)
            case ($urandom_range(0, 7))
                0: kb_val = 7'd1;
                1: kb_val = 7'd2;
                2: kb_val = 7'd8;
                3: kb_val = 7'd13;
                4: kb_val = 7'd16;
                5: kb_val = 7'd32;
                6: kb_val = 7'd63;
                default: kb_val = 7'd64;
            endcase
        else
            kb_val = (pick == 8) ? 7'd0 : 7'd127;
        // mostly narrow prefixes so a finish closes few buckets; upper data bits are don't-care
        pb_val = CFG_DATA_W'(($urandom_range(0, 7) << 4) |
                 (($urandom_range(0, 6) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 7)));
        case ($urandom_range(0, 2))
            0: write_reg(CFG_KEY_BITS, kb_val);
            1: write_reg(CFG_PREFIX_BITS, pb_val);
            default:
            begin
                write_reg(CFG_KEY_BITS, kb_val);
                write_reg(CFG_PREFIX_BITS, pb_val);
            end
        endcase
        if ($urandom_range(0, 9) == 0)
            write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
                      CFG_DATA_W'($urandom_range(0, 127)));
    endtask

    initial
    begin : stimulus
        logic [KEY_W-1:0] k;
        int               first_random;
        int               n_load;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full 64-bit keys, 12 prefix bits straight out of reset
        send_item(OP_LOAD, 64'd0);
        send_item(OP_LOAD, 64'd0);
        send_item(OP_LOAD, 64'h8000_0000_0000_0000);
        send_item(OP_LOAD, 64'd7);
        send_item(OP_LOAD, '1);
        send_item(OP_LOOKUP, 64'd5);
        send_item(OP_FINISH, '0);
        send_item(OP_FINISH, '1);
        send_item(OP_LOAD, '1);
        send_item(OP_LOOKUP, 64'd0);
        send_item(OP_LOOKUP, 64'h8000_0000_0000_0000);
        send_item(OP_LOOKUP, '1);
        send_item(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE);
        send_item(OP_CLEAR, '1);
        send_item(OP_LOOKUP, 64'd0);
        send_item(OP_FINISH, 64'd0);
        send_item(OP_LOOKUP, 64'd0);

        // key width zero acts as one bit, prefix capped to it
        write_reg(CFG_KEY_BITS, 7'd0);
        write_reg(CFG_PREFIX_BITS, 7'd15);
        send_item(OP_LOAD, 64'd2);
        send_item(OP_LOAD, 64'd1);
        send_item(OP_FINISH, 64'd0);
        send_item(OP_LOOKUP, 64'd2);
        send_item(OP_LOOKUP, 64'd1);

        // oversized key width, single bucket over the whole table
        write_reg(CFG_KEY_BITS, 7'd127);
        write_reg(CFG_PREFIX_BITS, 7'd0);
        send_item(OP_LOAD, 64'd10);
        send_item(OP_LOAD, 64'd20);
        send_item(OP_FINISH, 64'd0);
        write_reg(CFG_SPARE_HI, 7'd127);
        send_item(OP_LOOKUP, 64'd30);
        send_item(OP_LOOKUP, 64'd20);

        // a larger table under the full 12-bit prefix, then one more load
        write_reg(CFG_KEY_BITS, 7'd64);
        write_reg(CFG_PREFIX_BITS, 7'd12);
        k = '0;
        for (int i = 0; i < FILL_KEYS; i++)
        begin
            send_item(OP_LOAD, k);
            table_keys.push_back(k);
            k += ($urandom_range(0, 1) == 0) ? {32'd0, $urandom_range(1, 3)}
                                              : (rand_key() >> 13) + 64'd1;
        end
        send_item(OP_LOAD, k);
        table_keys.push_back(k);
        send_item(OP_FINISH, '0);
        send_item(OP_LOOKUP, table_keys[0]);
        send_item(OP_LOOKUP, table_keys[FILL_KEYS]);
        lookup_some(60);

        first_random = items_sent;
        while (items_sent - first_random < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) == 0)
                reconfigure();
            case ($urandom_range(0, 19))
                0, 1, 2:        n_load = $urandom_range(0, 3);
                3, 4, 5:        n_load = $urandom_range(25, 160);
                default:        n_load = $urandom_range(1, 24);
            endcase
            run_table(n_load, $urandom_range(4, 24));
        end

        drain_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d items and %0d replies over %0d register writes,",
                 items_sent, checked, cfg_writes);
        $display("including a table of %0d keys and key widths from 1 to 64 bits",
                 FILL_KEYS + 1);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
